FILE: rtl/lbt_pkg.sv
// lbt_pkg: shared types, operation codes and constants of the lease binding table
// no dependencies
`default_nettype none
package lbt_pkg;
  localparam int TableEntriesDefault = 64;
  localparam int ClientIdBytesDefault = 8;
  localparam logic [31:0] LeaseReset = 32'd3600;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_EXPIRE = 3'd2;
  localparam logic [2:0] OP_PURGE = 3'd3;
  localparam logic [2:0] OP_SEARCH = 3'd4;
  localparam logic [2:0] OP_ALLOC = 3'd5;
  localparam logic [2:0] OP_SETST = 3'd6;

  localparam logic [1:0] ST_PENDING = 2'd0;
  localparam logic [1:0] ST_ASSOC = 2'd1;
  localparam logic [1:0] ST_EXPIRED = 2'd2;

  localparam logic [1:0] ERR_OK = 2'd0;
  localparam logic [1:0] ERR_FULL = 2'd1;
  localparam logic [1:0] ERR_NONE = 2'd2;

  localparam logic [1:0] CFG_LEASE = 2'd0;
  localparam logic [1:0] CFG_FIRST = 2'd1;
  localparam logic [1:0] CFG_LAST = 2'd2;

  // scan kinds issued by the controller
  localparam logic [2:0] SC_FREE = 3'd0;
  localparam logic [2:0] SC_SEARCH = 3'd1;
  localparam logic [2:0] SC_OLDADDR = 3'd2;
  localparam logic [2:0] SC_EXPDYN = 3'd3;
  localparam logic [2:0] SC_EXPIRE = 3'd4;
  localparam logic [2:0] SC_PURGE = 3'd5;

  typedef struct packed {
    logic [2:0] operation;
    logic [5:0] entry_handle;
    logic [31:0] ip_address;
    logic [63:0] client_id;
    logic [3:0] client_id_len;
    logic [1:0] static_select;
    logic [1:0] status_filter;
    logic [1:0] new_status;
    logic [31:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic found;
    logic [5:0] entry_index;
    logic [31:0] granted_address;
    logic [1:0] result_status;
    logic result_static;
    logic [6:0] changed_count;
    logic [1:0] error_code;
  } rsp_t;

  typedef struct packed {
    logic scan_start;
    logic [2:0] scan_kind;
    logic write_add;
    logic pool_add;
    logic handle_op;
    logic emit_best;
    logic emit_none;
    logic [1:0] emit_err;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic best_hit;
    logic best_reusable;
    logic pool_ok;
    logic handle_ok;
  } sts_t;
endpackage
`default_nettype wire

FILE: rtl/lbt_if.sv
// lbt_if: valid/ready channel carrying one word of a payload type
// depends on nothing
`default_nettype none
interface lbt_if #(parameter type payload_t = logic) (input wire logic clk);
  logic valid;
  logic ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/lbt_datapath.sv
// lbt_datapath: entry storage, one-entry-per-cycle scan unit and result register
// depends on lbt_pkg
`default_nettype none
module lbt_datapath #(
  parameter int TABLE_ENTRIES = 64,
  parameter int CLIENT_ID_BYTES = 8,
  localparam int IW = $clog2(TABLE_ENTRIES)
) (
  input wire logic clk,
  input wire logic rst,
  input wire lbt_pkg::req_t req,
  input wire lbt_pkg::cmd_t cmd,
  output lbt_pkg::sts_t sts,
  output lbt_pkg::rsp_t rsp,
  input wire logic cfg_we,
  input wire logic [1:0] cfg_index,
  input wire logic [31:0] cfg_data
);
  import lbt_pkg::*;
  localparam int CW = 8 * CLIENT_ID_BYTES;
  localparam int LW = $clog2(CLIENT_ID_BYTES + 1);

  logic [TABLE_ENTRIES-1:0] valid;
  logic [31:0] mem_addr [TABLE_ENTRIES];
  logic [CW-1:0] mem_cid [TABLE_ENTRIES];
  logic [LW-1:0] mem_len [TABLE_ENTRIES];
  logic mem_stat [TABLE_ENTRIES];
  logic [1:0] mem_st [TABLE_ENTRIES];
  logic [31:0] mem_time [TABLE_ENTRIES];
  logic [31:0] mem_age [TABLE_ENTRIES];

  logic [31:0] lease_seconds, pool_last, next_free, ins_cnt;
  logic [IW:0] cnt;
  logic scanning;
  logic [2:0] kind;
  logic best_hit;
  logic best_reus;
  logic [IW-1:0] best_idx;
  logic [31:0] best_age;
  logic [6:0] changed;

  // registered copy of the entry being scanned
  logic [31:0] r_addr, r_time, r_age;
  logic [CW-1:0] r_cid;
  logic [LW-1:0] r_len;
  logic r_stat, r_valid, r_live;
  logic [1:0] r_st;
  logic [IW-1:0] r_idx;

  // normalized request
  logic [3:0] len_sat;
  logic [LW-1:0] len_n;
  logic [CW-1:0] cid_n;
  logic [1:0] st_new;
  always_comb begin
    len_sat = (req.client_id_len > 4'(CLIENT_ID_BYTES)) ? 4'(CLIENT_ID_BYTES)
                                                        : req.client_id_len;
    len_n = LW'(len_sat);
    for (int b = 0; b < CLIENT_ID_BYTES; b++) begin
      cid_n[8*b +: 8] = (4'(b) < len_sat) ? req.client_id[8*b +: 8] : 8'd0;
    end
    st_new = (req.new_status > ST_EXPIRED) ? ST_EXPIRED : req.new_status;
  end

  logic [IW-1:0] hidx;
  logic hin;
  assign hidx = IW'(req.entry_handle);
  assign hin = (32'(req.entry_handle) < 32'(TABLE_ENTRIES));

  // per-entry test
  logic [31:0] age, tdiff;
  logic match, better;
  always_comb begin
    age = ins_cnt - r_age;
    tdiff = (req.now_seconds >= r_time) ? req.now_seconds - r_time : 32'd0;
    match = 1'b0;
    case (kind)
      SC_FREE: match = !r_valid;
      SC_SEARCH: match = r_valid
        && (req.static_select[1] || r_stat == req.static_select[0])
        && r_len == len_n && r_cid == cid_n
        && (req.status_filter == 2'd0 || r_st == req.status_filter - 2'd1);
      SC_OLDADDR: match = r_valid && r_addr == req.ip_address;
      SC_EXPDYN: match = r_valid && !r_stat && r_st == ST_EXPIRED;
      SC_EXPIRE: match = r_valid && r_st == ST_PENDING && tdiff > lease_seconds;
      SC_PURGE: match = r_valid && r_st == ST_EXPIRED;
      default: match = 1'b0;
    endcase
    case (kind)
      SC_FREE: better = !best_hit;
      SC_OLDADDR: better = !best_hit || age > best_age;
      default: better = !best_hit || age < best_age;
    endcase
  end

  logic [IW-1:0] widx;
  assign widx = best_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      lease_seconds <= LeaseReset;
      pool_last <= '0;
      next_free <= '0;
      ins_cnt <= '0;
      scanning <= 1'b0;
      r_live <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LEASE: lease_seconds <= cfg_data;
          CFG_FIRST: next_free <= cfg_data;
          CFG_LAST: pool_last <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.scan_start) begin
        scanning <= 1'b1;
        kind <= cmd.scan_kind;
        cnt <= '0;
        best_hit <= 1'b0;
        changed <= '0;
        r_live <= 1'b0;
      end else begin
        r_live <= scanning;
        if (scanning) begin
          cnt <= cnt + (IW+1)'(1);
          if (cnt == (IW+1)'(TABLE_ENTRIES - 1)) scanning <= 1'b0;
        end
        if (r_live && match) begin
          if (kind == SC_EXPIRE) begin
            mem_st[r_idx] <= ST_EXPIRED;
            if (changed != 7'd127) changed <= changed + 7'd1;
          end else if (kind == SC_PURGE) begin
            valid[r_idx] <= 1'b0;
            if (changed != 7'd127) changed <= changed + 7'd1;
          end else if (better) begin
            best_hit <= 1'b1;
            best_idx <= r_idx;
            best_age <= age;
            // dynamic and expired: reusable by allocate
            best_reus <= !r_stat && r_st == ST_EXPIRED;
          end
        end
      end
      if (cmd.write_add) begin
        valid[widx] <= 1'b1;
        mem_addr[widx] <= cmd.pool_add ? next_free : req.ip_address;
        mem_cid[widx] <= cid_n;
        mem_len[widx] <= len_n;
        mem_stat[widx] <= cmd.pool_add ? 1'b0 : (req.static_select != 2'd0);
        mem_st[widx] <= ST_PENDING;
        mem_time[widx] <= req.now_seconds;
        mem_age[widx] <= ins_cnt;
        ins_cnt <= ins_cnt + 32'd1;
        if (cmd.pool_add) next_free <= next_free + 32'd1;
      end
      if (cmd.handle_op && hin && valid[hidx]) begin
        if (req.operation == OP_SETST)
          mem_st[hidx] <= st_new;
        else
          valid[hidx] <= 1'b0;
      end
    end
  end

  // memory read, one entry per cycle
  always_ff @(posedge clk) begin
    r_idx <= cnt[IW-1:0];
    r_valid <= valid[cnt[IW-1:0]];
    r_addr <= mem_addr[cnt[IW-1:0]];
    r_cid <= mem_cid[cnt[IW-1:0]];
    r_len <= mem_len[cnt[IW-1:0]];
    r_stat <= mem_stat[cnt[IW-1:0]];
    r_st <= mem_st[cnt[IW-1:0]];
    r_time <= mem_time[cnt[IW-1:0]];
    r_age <= mem_age[cnt[IW-1:0]];
  end

  // result register: emit reads the chosen entry's fields
  logic [IW-1:0] eidx;
  logic ehit;
  always_comb begin
    ehit = cmd.emit_none ? 1'b0 : cmd.handle_op ? (hin && valid[hidx]) : best_hit;
    eidx = cmd.handle_op ? hidx : best_idx;
  end
  always_ff @(posedge clk) begin
    if (cmd.emit_best) begin
      rsp.found <= ehit;
      rsp.entry_index <= ehit ? 6'(eidx) : 6'd0;
      rsp.granted_address <= ehit ? mem_addr[eidx] : 32'd0;
      // set status reports the status just written
      rsp.result_status <= !ehit ? 2'd0
                           : (cmd.handle_op && req.operation == OP_SETST) ? st_new
                           : mem_st[eidx];
      rsp.result_static <= ehit ? mem_stat[eidx] : 1'b0;
      rsp.changed_count <= (kind == SC_EXPIRE || kind == SC_PURGE) && !cmd.handle_op
                           && !cmd.emit_none ? changed : 7'd0;
      rsp.error_code <= cmd.emit_err;
    end
  end

  assign sts.scan_done = !scanning && !r_live && !cmd.scan_start;
  assign sts.best_hit = best_hit;
  assign sts.best_reusable = best_hit && best_reus;
  assign sts.pool_ok = next_free != 32'd0 && next_free <= pool_last;
  assign sts.handle_ok = hin && valid[hidx];
endmodule
`default_nettype wire

FILE: rtl/lbt_ctrl.sv
// lbt_ctrl: operation sequencer driving the scan datapath
// depends on lbt_pkg
`default_nettype none
module lbt_ctrl (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire logic [2:0] op,
  input wire logic [31:0] ip,
  output logic out_valid,
  input wire logic out_ready,
  output lbt_pkg::cmd_t cmd,
  input wire lbt_pkg::sts_t sts
);
  import lbt_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_SCAN1 = 4'd1, S_WAIT1 = 4'd2,
    S_DEC1 = 4'd3, S_SCAN2 = 4'd4, S_WAIT2 = 4'd5, S_DEC2 = 4'd6,
    S_SCAN3 = 4'd7, S_WAIT3 = 4'd8, S_EMIT = 4'd9, S_OUT = 4'd10;
  logic [3:0] state, state_next;
  logic [1:0] err, err_next;
  logic out_hold;

  assign in_ready = (state == S_IDLE) && !out_hold;
  assign out_valid = out_hold;

  always_comb begin
    state_next = state;
    err_next = err;
    cmd = '0;
    case (state)
      S_IDLE: if (in_valid && in_ready) begin
        case (op)
          OP_REMOVE, OP_SETST: begin
            cmd.handle_op = 1'b1;
            cmd.emit_best = 1'b1;
            cmd.emit_err = sts.handle_ok ? ERR_OK : ERR_NONE;
            state_next = S_OUT;
          end
          OP_ADD, OP_EXPIRE, OP_PURGE, OP_SEARCH: begin
            cmd.scan_start = 1'b1;
            cmd.scan_kind = (op == OP_ADD) ? SC_FREE : (op == OP_EXPIRE) ? SC_EXPIRE :
                            (op == OP_PURGE) ? SC_PURGE : SC_SEARCH;
            state_next = S_WAIT1;
          end
          OP_ALLOC: begin
            if (ip != 32'd0) begin
              cmd.scan_start = 1'b1;
              cmd.scan_kind = SC_OLDADDR;
              state_next = S_WAIT2;
            end else state_next = S_DEC2;
          end
          // unknown operation: empty word with nothing found
          default: begin
            cmd.emit_best = 1'b1;
            cmd.emit_none = 1'b1;
            cmd.emit_err = ERR_NONE;
            state_next = S_OUT;
          end
        endcase
      end
      S_WAIT1: if (sts.scan_done) state_next = S_DEC1;
      S_DEC1: begin
        cmd.emit_best = 1'b1;
        if (op == OP_ADD) begin
          cmd.write_add = sts.best_hit;
          cmd.emit_err = sts.best_hit ? ERR_OK : ERR_FULL;
          state_next = S_EMIT;
        end else begin
          cmd.emit_err = (op == OP_SEARCH && !sts.best_hit) ? ERR_NONE : ERR_OK;
          state_next = S_OUT;
        end
      end
      S_WAIT2: if (sts.scan_done) begin
        if (sts.best_reusable) begin
          state_next = S_OUT;
          cmd.emit_best = 1'b1;
          cmd.emit_err = ERR_OK;
        end else state_next = S_DEC2;
      end
      S_DEC2: begin
        cmd.scan_start = 1'b1;
        cmd.scan_kind = sts.pool_ok ? SC_FREE : SC_EXPDYN;
        state_next = sts.pool_ok ? S_SCAN2 : S_WAIT3;
      end
      S_SCAN2: if (sts.scan_done) begin
        cmd.emit_best = 1'b1;
        cmd.write_add = sts.best_hit;
        cmd.pool_add = sts.best_hit;
        cmd.emit_err = sts.best_hit ? ERR_OK : ERR_FULL;
        state_next = S_EMIT;
      end
      S_WAIT3: if (sts.scan_done) begin
        cmd.emit_best = 1'b1;
        cmd.emit_err = sts.best_hit ? ERR_OK : ERR_NONE;
        state_next = S_OUT;
      end
      // re-emit after an add so the fields show the written entry
      S_EMIT: begin
        cmd.emit_best = 1'b1;
        cmd.emit_err = err;
        state_next = S_OUT;
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (cmd.emit_best && state != S_EMIT) err_next = cmd.emit_err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      err <= ERR_OK;
      out_hold <= 1'b0;
    end else begin
      state <= state_next;
      err <= err_next;
      if (state == S_OUT) out_hold <= 1'b1;
      else if (out_ready) out_hold <= 1'b0;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/lease_binding_table_top.sv
// lease_binding_table_top: lease binding table with request and result channels
// depends on lbt_pkg, lbt_if, lbt_ctrl, lbt_datapath
`default_nettype none
// usage:
//   req carries one operation word (add, remove, expire, purge, search,
//   allocate, set status); rsp returns exactly one result word for it.
//   the user writes lease_seconds, pool_first, pool_last via the cfg port
//   only while idle (unenforced); writing pool_first reloads the pool pointer.
// timing:
//   remove and set status run no scan; add, expire, purge and
//   search run one scan of the table, one entry per cycle; allocate
//   may run two scans. the scan pace is set by the single read port
//   of the entry memory.
// reset:
//   clears every valid bit, the insertion counter and the pool pointer,
//   and restores lease_seconds to 3600; entry fields are not cleared.
// stall:
//   a finished word stays in the result register until rsp.ready; no new
//   request is taken until then, one operation is in flight at a time.
module lease_binding_table_top #(
  parameter int TABLE_ENTRIES = lbt_pkg::TableEntriesDefault,
  parameter int CLIENT_ID_BYTES = lbt_pkg::ClientIdBytesDefault
) (
  input wire logic clk,
  input wire logic rst,
  lbt_if.sink req,
  lbt_if.source rsp,
  input wire logic cfg_we,
  input wire logic [1:0] cfg_index,
  input wire logic [31:0] cfg_data
);
  import lbt_pkg::*;
  cmd_t cmd;
  sts_t sts;
  req_t rq;
  req_t rq_hold;
  rsp_t rs;

  // request word is held across the operation
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) rq_hold <= req.payload;
  end
  assign rq = (req.valid && req.ready) ? req.payload : rq_hold;

  lbt_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .op(rq.operation), .ip(rq.ip_address),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .cmd(cmd), .sts(sts)
  );

  lbt_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .CLIENT_ID_BYTES(CLIENT_ID_BYTES)) u_dp (
    .clk(clk), .rst(rst), .req(rq), .cmd(cmd), .sts(sts), .rsp(rs),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  assign rsp.payload = rs;
endmodule
`default_nettype wire

FILE: tb/lease_binding_table_top_test.sv
// lease_binding_table_top_test: self-checking test of the lease binding table
// drives operation words through lbt_if, predicts each result word, checks in order
// depends on lbt_pkg, lbt_if and lease_binding_table_top
`timescale 1ns / 100ps
module lease_binding_table_top_test;
  import lbt_pkg::*;

  localparam int NENT = 64;
  localparam int LIMIT_CYCLES = 900000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  lbt_if #(.payload_t(req_t)) req (clk);
  lbt_if #(.payload_t(rsp_t)) rsp (clk);

  lease_binding_table_top u_dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predicted copy of the table
  logic        tbl_valid [NENT];
  logic [31:0] tbl_addr [NENT];
  logic [63:0] tbl_cid [NENT];
  logic [3:0]  tbl_len [NENT];
  logic        tbl_static [NENT];
  logic [1:0]  tbl_status [NENT];
  logic [31:0] tbl_bound [NENT];
  logic [31:0] tbl_order [NENT];
  logic [31:0] ins_count;
  logic [31:0] pool_ptr;
  logic [31:0] lease_len, pool_lo, pool_hi;

  rsp_t expected_words[$];
  int   failures;
  int   cycle_count;
  bit   rx_hold;      // long receiver hold-off request
  bit   idle_free;    // stretch with no idling on either side

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic rsp_t entry_word(int idx, logic [1:0] err);
    rsp_t w;
    w = '0;
    if (idx >= 0) begin
      w.found = 1'b1;
      w.entry_index = idx[5:0];
      w.granted_address = tbl_addr[idx];
      w.result_status = tbl_status[idx];
      w.result_static = tbl_static[idx];
    end
    w.error_code = err;
    return w;
  endfunction

  function automatic int table_insert(logic [31:0] a, logic [63:0] c, logic [3:0] l,
                                      logic s, logic [31:0] now);
    for (int i = 0; i < NENT; i++) begin
      if (!tbl_valid[i]) begin
        tbl_valid[i] = 1'b1;
        tbl_addr[i] = a;
        tbl_cid[i] = c;
        tbl_len[i] = l;
        tbl_static[i] = s;
        tbl_status[i] = ST_PENDING;
        tbl_bound[i] = now;
        tbl_order[i] = ins_count;
        ins_count = ins_count + 1;
        return i;
      end
    end
    return -1;
  endfunction

  // computes the result word of one operation and updates the table copy
  function automatic rsp_t lease_result(req_t r);
    rsp_t w;
    logic [3:0] l;
    logic [63:0] c;
    logic [31:0] age, best_age;
    int best, idx, cnt;
    l = (r.client_id_len > 4'd8) ? 4'd8 : r.client_id_len;
    c = (l == 4'd8) ? r.client_id : r.client_id & ((64'd1 << (8 * l)) - 64'd1);
    best = -1;
    best_age = '0;
    cnt = 0;
    w = entry_word(-1, ERR_NONE);
    case (r.operation)
      OP_ADD: begin
        idx = table_insert(r.ip_address, c, l, r.static_select != 2'd0, r.now_seconds);
        w = entry_word(idx, idx < 0 ? ERR_FULL : ERR_OK);
      end
      OP_REMOVE, OP_SETST: begin
        if (tbl_valid[r.entry_handle]) begin
          if (r.operation == OP_SETST)
            tbl_status[r.entry_handle] = (r.new_status > 2'd2) ? ST_EXPIRED : r.new_status;
          else
            tbl_valid[r.entry_handle] = 1'b0;
          w = entry_word(r.entry_handle, ERR_OK);
        end
      end
      OP_EXPIRE, OP_PURGE: begin
        for (int i = 0; i < NENT; i++) begin
          if (!tbl_valid[i]) continue;
          if (r.operation == OP_EXPIRE) begin
            age = (r.now_seconds >= tbl_bound[i]) ? r.now_seconds - tbl_bound[i] : '0;
            if (tbl_status[i] == ST_PENDING && age > lease_len) begin
              tbl_status[i] = ST_EXPIRED;
              cnt++;
            end
          end else if (tbl_status[i] == ST_EXPIRED) begin
            tbl_valid[i] = 1'b0;
            cnt++;
          end
        end
        w = entry_word(-1, ERR_OK);
        w.changed_count = (cnt > 127) ? 7'd127 : cnt[6:0];
      end
      OP_SEARCH: begin
        for (int i = 0; i < NENT; i++) begin
          if (!tbl_valid[i]) continue;
          if (r.static_select < 2'd2 && tbl_static[i] != r.static_select[0]) continue;
          if (tbl_len[i] != l || tbl_cid[i] != c) continue;
          if (r.status_filter != 2'd0 && tbl_status[i] != r.status_filter - 2'd1) continue;
          age = ins_count - tbl_order[i];
          if (best < 0 || age < best_age) begin
            best = i;
            best_age = age;
          end
        end
        w = entry_word(best, best < 0 ? ERR_NONE : ERR_OK);
      end
      OP_ALLOC: begin
        if (r.ip_address != '0) begin
          // oldest entry holding the requested address
          for (int i = 0; i < NENT; i++) begin
            if (!tbl_valid[i] || tbl_addr[i] != r.ip_address) continue;
            age = ins_count - tbl_order[i];
            if (best < 0 || age > best_age) begin
              best = i;
              best_age = age;
            end
          end
        end
        if (best >= 0 && !tbl_static[best] && tbl_status[best] == ST_EXPIRED) begin
          w = entry_word(best, ERR_OK);
        end else if (pool_ptr != '0 && pool_ptr <= pool_hi) begin
          idx = table_insert(pool_ptr, c, l, 1'b0, r.now_seconds);
          if (idx < 0) begin
            w = entry_word(-1, ERR_FULL);
          end else begin
            pool_ptr = pool_ptr + 1;
            w = entry_word(idx, ERR_OK);
          end
        end else begin
          // newest expired dynamic entry
          best = -1;
          for (int i = 0; i < NENT; i++) begin
            if (!tbl_valid[i] || tbl_static[i] || tbl_status[i] != ST_EXPIRED) continue;
            age = ins_count - tbl_order[i];
            if (best < 0 || age < best_age) begin
              best = i;
              best_age = age;
            end
          end
          w = entry_word(best, best < 0 ? ERR_NONE : ERR_OK);
        end
      end
      default: w = entry_word(-1, ERR_NONE);
    endcase
    return w;
  endfunction

  // sends one word; the prediction is made at the accepting edge
  // valid stays up after the word until the next idle cycle or drain
  task automatic send_word(req_t r);
    while (!idle_free && $urandom_range(99) < 16) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.payload <= r;
    req.valid <= 1'b1;
    do @(posedge clk); while (!req.ready);
    expected_words.push_back(lease_result(r));
    @(negedge clk);
  endtask

  // result checker and receiver stalls
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        rsp.ready <= 1'b0;
        repeat (400) @(negedge clk);
        rx_hold = 1'b0;
      end
      rsp.ready <= idle_free || ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word %h", $realtime, rsp.payload);
        failures++;
      end else begin
        e = expected_words.pop_front();
        if (e !== rsp.payload) begin
          $display("%0t mismatch: expected %h actual %h", $realtime, e, rsp.payload);
          failures++;
        end
      end
    end
  end

  task automatic drain();
    req.valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (2 * NENT + 20) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_LEASE: lease_len = v;
      CFG_FIRST: begin
        pool_lo = v;
        pool_ptr = v;
      end
      default: pool_hi = v;
    endcase
  endtask

  function automatic req_t make_word(logic [2:0] op);
    req_t r;
    r = '0;
    r.operation = op;
    r.entry_handle = 6'($urandom_range(63));
    r.ip_address = $urandom_range(3) == 0 ? 32'd0 : 32'h0A00_0000 + $urandom_range(15);
    r.client_id_len = $urandom_range(9) == 0 ? 4'($urandom_range(15))
                                             : 4'($urandom_range(8));
    // small id pool so that searches hit
    r.client_id = {$urandom_range(1) ? $urandom : 32'd0, 28'd0, 4'($urandom_range(3))};
    if ($urandom_range(9) == 0) r.client_id = {$urandom, $urandom};
    r.static_select = 2'($urandom_range(3));
    r.status_filter = 2'($urandom_range(3));
    r.new_status = 2'($urandom_range(3));
    r.now_seconds = $urandom_range(12000);
    if ($urandom_range(19) == 0) r.now_seconds = $urandom;
    return r;
  endfunction

  task automatic random_ops(int n);
    req_t r;
    logic [2:0] op;
    for (int k = 0; k < n; k++) begin
      op = $urandom_range(9) == 0 ? 3'd7 : 3'($urandom_range(6));
      r = make_word(op);
      // keep removes and status writes mostly on live entries
      if ((op == OP_REMOVE || op == OP_SETST) && $urandom_range(3) != 0)
        r.entry_handle = 6'($urandom_range(15));
      send_word(r);
    end
  endtask

  // field extremes, every operation, reuse of an expired dynamic entry
  task automatic test_directed();
    req_t r;
    r = '0;
    r.operation = OP_ADD; r.client_id = '1; r.client_id_len = 4'hF;
    r.ip_address = '1; r.static_select = 2'd3; r.now_seconds = '1; send_word(r);
    r = '0; r.operation = OP_ADD; r.client_id = '1; r.client_id_len = 4'd3;
    r.ip_address = 32'h0A00_0001; send_word(r);
    r.operation = OP_SEARCH; r.static_select = 2'd3; send_word(r);
    r.operation = OP_SETST; r.entry_handle = 6'd1; r.new_status = 2'd3; send_word(r);
    r.operation = OP_ALLOC; r.ip_address = 32'h0A00_0001; send_word(r);
    r.operation = OP_SETST; r.entry_handle = 6'd63; send_word(r);
    r = '0; r.operation = OP_EXPIRE; r.now_seconds = 32'd5000; send_word(r);
    r.operation = OP_PURGE; send_word(r);
    r.operation = OP_REMOVE; r.entry_handle = 6'd0; send_word(r);
    r.operation = 3'd7; r.entry_handle = '1; r.status_filter = 2'd3; send_word(r);
    drain();
  endtask

  task automatic test_table_full();
    req_t r;
    for (int k = 0; k < NENT + 2; k++) begin
      r = make_word(OP_ADD);
      send_word(r);
    end
    r = make_word(OP_ALLOC); r.ip_address = '0; send_word(r);
    r = '0; r.operation = OP_EXPIRE; r.now_seconds = '1; send_word(r);
    r.operation = OP_PURGE; send_word(r);
    drain();
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    rx_hold = 1'b1;
    random_ops(12);
    drain();
  endtask

  task automatic test_random_phases();
    write_reg(CFG_LEASE, 32'd1);
    write_reg(CFG_FIRST, 32'h0A00_0001);
    write_reg(CFG_LAST, 32'h0A00_000C);
    random_ops(350);
    drain();
    write_reg(CFG_LEASE, 32'hFFFF_FFFF);
    write_reg(CFG_FIRST, 32'hFFFF_FFFE);
    write_reg(CFG_LAST, 32'hFFFF_FFFF);
    idle_free = 1'b1;
    random_ops(250);
    idle_free = 1'b0;
    drain();
    write_reg(CFG_LEASE, 32'd3000);
    write_reg(CFG_FIRST, 32'h0A00_0003);
    write_reg(CFG_LAST, 32'h0A00_0000);
    random_ops(300);
    drain();
    write_reg(CFG_FIRST, 32'h0A00_0000);
    write_reg(CFG_LAST, 32'h0A00_00FF);
    random_ops(350);
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    req.valid = 1'b0; req.payload = '0;
    failures = 0; cycle_count = 0;
    rx_hold = 1'b0; idle_free = 1'b0;
    for (int i = 0; i < NENT; i++) tbl_valid[i] = 1'b0;
    ins_count = '0; pool_ptr = '0;
    lease_len = LeaseReset; pool_lo = '0; pool_hi = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_table_full();
    test_backpressure();
    test_random_phases();
    drain();
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
